@@ rtl/utf8sd_pkg.sv @@
`default_nettype none

package utf8sd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 31;
  localparam int unsigned LenW  = 3;
  localparam int unsigned StatW = 2;

  // Result status codes
  typedef enum logic [StatW-1:0] {
    ST_OK  = 2'd0,
    ST_ERR = 2'd1,
    ST_END = 2'd2
  } status_e;

  // One decoded result, valid only when valid is set
  typedef struct packed {
    logic             valid;
    logic [CodeW-1:0] char_code;
    logic [LenW-1:0]  seq_length;
    status_e          status;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/utf8sd_decode.sv @@
`default_nettype none

module utf8sd_decode import utf8sd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire logic [ByteW-1:0] byte_i,
  output result_t               res_o
);

  logic [LenW-1:0]  pending_q, pending_d;
  logic [CodeW-1:0] partial_q, partial_d;
  logic [LenW-1:0]  total_q, total_d;
  logic             is_cont;
  logic [CodeW-1:0] shifted;

  assign is_cont = (byte_i[7:6] == 2'b10);
  assign shifted = {partial_q[CodeW-7:0], byte_i[5:0]};

  always_comb begin
    pending_d = pending_q;
    partial_d = partial_q;
    total_d   = total_q;
    res_o     = '{valid: 1'b0, char_code: '0, seq_length: '0, status: ST_OK};

    if (pending_q != '0) begin
      if (!is_cont) begin
        // broken sequence: drop it and flag the byte
        pending_d    = '0;
        partial_d    = '0;
        total_d      = '0;
        res_o.valid  = 1'b1;
        res_o.status = ST_ERR;
      end else if (pending_q == LenW'(1)) begin
        pending_d        = '0;
        partial_d        = '0;
        total_d          = '0;
        res_o.valid      = 1'b1;
        res_o.char_code  = shifted;
        res_o.seq_length = total_q;
        res_o.status     = ST_OK;
      end else begin
        pending_d = pending_q - LenW'(1);
        partial_d = shifted;
      end
    end else begin
      priority if (byte_i == '0) begin
        res_o.valid  = 1'b1;
        res_o.status = ST_END;
      end else if (!byte_i[7]) begin
        res_o.valid      = 1'b1;
        res_o.char_code  = CodeW'(byte_i);
        res_o.seq_length = LenW'(1);
        res_o.status     = ST_OK;
      end else if (!byte_i[6]) begin
        res_o.valid  = 1'b1;
        res_o.status = ST_ERR;
      end else if (!byte_i[5]) begin
        partial_d = CodeW'(byte_i[4:0]);
        total_d   = LenW'(2);
        pending_d = LenW'(1);
      end else if (!byte_i[4]) begin
        partial_d = CodeW'(byte_i[3:0]);
        total_d   = LenW'(3);
        pending_d = LenW'(2);
      end else if (!byte_i[3]) begin
        partial_d = CodeW'(byte_i[2:0]);
        total_d   = LenW'(4);
        pending_d = LenW'(3);
      end else if (!byte_i[2]) begin
        partial_d = CodeW'(byte_i[1:0]);
        total_d   = LenW'(5);
        pending_d = LenW'(4);
      end else if (!byte_i[1]) begin
        partial_d = CodeW'(byte_i[0]);
        total_d   = LenW'(6);
        pending_d = LenW'(5);
      end else begin
        res_o.valid  = 1'b1;
        res_o.status = ST_ERR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      partial_q <= '0;
      total_q   <= '0;
    end else if (fire_i) begin
      pending_q <= pending_d;
      partial_q <= partial_d;
      total_q   <= total_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/utf8_stream_decoder_core.sv @@
// Byte-serial UTF-8 decoder. Feed one word (a raw byte) per handshake on
// in_*; complete sequences, errors and NUL terminators come out as one word
// each on out_*. Legacy five- and six-byte lead forms are decoded, giving
// code points of up to 31 bits; overlong forms pass unchecked. A stray
// continuation, a 0xFE/0xFF lead, or a non-continuation byte inside a
// sequence yields status 1 (the offending byte is consumed and the decoder
// returns to idle); a NUL lead yields status 2. The block sustains one byte
// per cycle while the output is not stalled: each byte passes through an input
// register, one shallow decode step and an output register, and a stalled
// output holds one result while the next byte is already registered. Sequence
// bytes that complete no word produce no output.
`default_nettype none

module utf8_stream_decoder_core import utf8sd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] in_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [CodeW-1:0]      char_code_o,
  output logic [LenW-1:0]       seq_length_o,
  output logic [StatW-1:0]      status_o
);

  // Input register: holds one byte waiting for the decode step
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;

  // Output register: holds one finished word until taken
  logic             out_valid_q;
  logic [CodeW-1:0] char_code_q;
  logic [LenW-1:0]  seq_length_q;
  status_e          status_q;

  logic    fire;
  logic    out_free;
  result_t res;

  // The output register can take a new word when empty or being drained.
  assign out_free   = !out_valid_q || out_ready_i;
  // Advance the decoder on the registered byte when the result has a home.
  assign fire       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
  end

  utf8sd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  // Valid flag of the output register: load a word, or drop the taken one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.valid) begin
      char_code_q  <= res.char_code;
      seq_length_q <= res.seq_length;
      status_q     <= res.status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign char_code_o  = char_code_q;
  assign seq_length_o = seq_length_q;
  assign status_o     = status_q;

  // A non-ok word carries neither a value nor a length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (char_code_o == '0 && seq_length_o == '0))
    else $error("error or end word carries data");

  // An ok word has a length between one and six.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_OK) |-> (seq_length_o != '0 && seq_length_o <= LenW'(6)))
    else $error("ok word with bad length");

  // A registered byte that cannot be decoded must block new input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while decode stage stalled");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none

module tb;
  import utf8sd_pkg::*;

  // Cycles with work outstanding but no handshake on either side
  localparam int unsigned StallLimit = 2000;
  // Cycles to keep watching the output after the last expected word
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomBytes = 400;
  // Accepted bytes per idling phase
  localparam int unsigned PhaseLen = 60;

  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             in_valid   = 1'b0;
  logic [ByteW-1:0] in_byte    = '0;
  logic             out_ready  = 1'b0;
  logic             in_ready;
  logic             out_valid;
  logic [CodeW-1:0] char_code;
  logic [LenW-1:0]  seq_length;
  logic [StatW-1:0] status;

  utf8_stream_decoder_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .in_byte_i    (in_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .char_code_o  (char_code),
    .seq_length_o (seq_length),
    .status_o     (status)
  );

  // Bytes still to be offered, and decoded words still owed by the block
  logic [ByteW-1:0] byte_q[$];
  result_t          decoded_q[$];

  // Directed words: one-byte extremes, sample two-, three- and four-byte words,
  // the largest six-byte value, bad leads, stray continuation, broken and NUL-cut sequences
  logic [ByteW-1:0] directed[] = '{
    8'h00, 8'h01, 8'h7F, 8'h80, 8'hBF, 8'hFE, 8'hFF,
    8'hDF, 8'hBF,
    8'hE0, 8'h80, 8'h80,
    8'hF4, 8'h8F, 8'hBF, 8'hBF,
    8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
    8'hF8, 8'h41,
    8'hC3, 8'h00
  };

  // Decoder state of the prediction, kept apart from the block
  logic [2:0]       cont_left   = '0;
  logic [CodeW-1:0] cp_acc      = '0;
  logic [LenW-1:0]  lead_length = '0;

  int unsigned bytes_in   = 0;
  int unsigned mismatches = 0;
  int unsigned n_ok       = 0;
  int unsigned n_bad      = 0;
  int unsigned n_nul      = 0;
  int unsigned quiet      = 0;

  int unsigned phase;
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  // Cycle through the idling phases as bytes go in: none, sender idle,
  // receiver stalling, then both at once
  assign phase         = (bytes_in / PhaseLen) % 4;
  assign send_idle_pct = (phase == 1) ? 48 : (phase == 3) ? 19 : 0;
  assign stall_pct     = (phase == 2) ? 48 : (phase == 3) ? 19 : 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Advance the predicted decoder by one byte; return the word it owes,
  // with valid clear when the byte only extends a sequence.
  function automatic result_t decode_byte(input logic [ByteW-1:0] b);
    result_t          r;
    logic [LenW-1:0]  len;
    logic [ByteW-1:0] payload;
    r         = '0;
    r.status  = ST_OK;
    len       = '0;
    payload   = '0;
    if (cont_left != 0) begin
      if (b[7:6] != 2'b10) begin
        // Anything but a continuation breaks the sequence; drop it all
        cont_left   = '0;
        cp_acc      = '0;
        lead_length = '0;
        r.valid     = 1'b1;
        r.status    = ST_ERR;
      end else begin
        cp_acc    = {cp_acc[CodeW-7:0], b[5:0]};
        cont_left = cont_left - 3'd1;
        if (cont_left == 0) begin
          r.valid      = 1'b1;
          r.char_code  = cp_acc;
          r.seq_length = lead_length;
          cp_acc       = '0;
          lead_length  = '0;
        end
      end
    end else if (b == 8'h00) begin
      r.valid  = 1'b1;
      r.status = ST_END;
    end else if (b < 8'h80) begin
      r.valid      = 1'b1;
      r.char_code  = {{(CodeW-ByteW){1'b0}}, b};
      r.seq_length = 3'd1;
    end else begin
      // Lead byte: the run of leading ones sets the length
      if (b < 8'hC0) begin
        len = 3'd0;
      end else if (b < 8'hE0) begin
        len = 3'd2; payload = b & 8'h1F;
      end else if (b < 8'hF0) begin
        len = 3'd3; payload = b & 8'h0F;
      end else if (b < 8'hF8) begin
        len = 3'd4; payload = b & 8'h07;
      end else if (b < 8'hFC) begin
        len = 3'd5; payload = b & 8'h03;
      end else if (b < 8'hFE) begin
        len = 3'd6; payload = b & 8'h01;
      end
      if (len == 0) begin
        // Stray continuation or 0xFE/0xFF: reject and stay idle
        r.valid  = 1'b1;
        r.status = ST_ERR;
      end else begin
        cp_acc      = {{(CodeW-ByteW){1'b0}}, payload};
        lead_length = len;
        cont_left   = len - 3'd1;
      end
    end
    return r;
  endfunction

  // Queue a lead byte for a sequence of seq_len bytes followed by
  // n_bytes-1 continuations with random payload
  task automatic push_sequence(input int unsigned seq_len, input int unsigned n_bytes);
    logic [ByteW-1:0] lead;
    lead = ByteW'($urandom);
    case (seq_len)
      1: begin
        lead = ByteW'($urandom_range(0, 127));
      end
      2: begin
        lead = 8'hC0 | (lead & 8'h1F);
      end
      3: begin
        lead = 8'hE0 | (lead & 8'h0F);
      end
      4: begin
        lead = 8'hF0 | (lead & 8'h07);
      end
      5: begin
        lead = 8'hF8 | (lead & 8'h03);
      end
      default: begin
        lead = 8'hFC | (lead & 8'h01);
      end
    endcase
    byte_q.push_back(lead);
    for (int unsigned i = 1; i < n_bytes; i++) begin
      byte_q.push_back(8'h80 | (ByteW'($urandom) & 8'h3F));
    end
  endtask

  initial begin
    int unsigned      kind;
    int unsigned      len;
    logic [ByteW-1:0] breaker;

    foreach (directed[i]) byte_q.push_back(directed[i]);

    // Mostly well-formed sequences, the rest truncated ones and raw noise
    while (byte_q.size() < directed.size() + RandomBytes) begin
      kind = $urandom_range(99);
      len  = $urandom_range(1, 6);
      if (kind < 70) begin
        push_sequence(len, len);
      end else if (kind < 85 && len > 1) begin
        push_sequence(len, $urandom_range(1, len - 1));
        breaker = ByteW'($urandom);
        if (breaker[7:6] == 2'b10) breaker[6] = 1'b1;
        byte_q.push_back(breaker);
      end else begin
        byte_q.push_back(ByteW'($urandom));
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hold until every byte is in and every owed word has come out
    while (byte_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("tb: %0d bytes decoded, %0d code points, %0d malformed, %0d NUL words",
             bytes_in, n_ok, n_bad, n_nul);
    $display("tb: idling phases cycled every %0d bytes", PhaseLen);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Driver: offer the next byte once the current word is taken, or hold
  // off at random; valid stays up with the byte unchanged until accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      in_byte   <= '0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
      if (!in_valid || in_ready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_byte  <= byte_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output word against the oldest prediction, then
  // feed any accepted byte into the prediction.
  always @(posedge clk_i) begin
    result_t exp_word;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected word: expected none, got cp %0h len %0d status %0d",
                   $time, char_code, seq_length, status);
          mismatches++;
        end else begin
          exp_word = decoded_q.pop_front();
          if (char_code != exp_word.char_code) begin
            $display("%0t: char_code mismatch: expected %0h, got %0h",
                     $time, exp_word.char_code, char_code);
            mismatches++;
          end
          if (seq_length != exp_word.seq_length) begin
            $display("%0t: seq_length mismatch: expected %0d, got %0d",
                     $time, exp_word.seq_length, seq_length);
            mismatches++;
          end
          if (status != exp_word.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, exp_word.status, status);
            mismatches++;
          end
          case (exp_word.status)
            ST_OK:   n_ok++;
            ST_ERR:  n_bad++;
            default: n_nul++;
          endcase
        end
      end
      if (in_valid && in_ready) begin
        exp_word = decode_byte(in_byte);
        if (exp_word.valid) decoded_q.push_back(exp_word);
        bytes_in <= bytes_in + 1;
      end
    end
  end

  // Watchdog: give up if work is outstanding and nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet <= 0;
      end else if (byte_q.size() != 0 || in_valid || decoded_q.size() != 0) begin
        if (quiet >= StallLimit) begin
          $display("%0t: no handshake for %0d cycles", $time, StallLimit);
          $display("tb: failure");
          $finish;
        end else begin
          quiet <= quiet + 1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ utf8_stream_decoder_core.f @@
rtl/utf8sd_pkg.sv
rtl/utf8sd_decode.sv
rtl/utf8_stream_decoder_core.sv
dv/tb.sv
